// File: src/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is high.
`define CLAS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication, disabled while reset is high.
`define CLAS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CLAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/clas_pkg.sv
// Package with the constants and control structs of the cache line access splitter.
`timescale 1ns / 1ps
package clas_pkg;

  localparam int ADDR_W      = 64;
  localparam int SIZE_W      = 10;
  localparam int OFF_W       = 9;
  localparam int SHIFT_W     = 4;
  localparam int LINE_W      = 13;
  localparam int CNT_W       = 6;

  localparam int MAX_ACCESS   = 512;
  localparam int DATA_CAP     = 64;
  localparam int RESULT_LIMIT = 33;
  localparam int SHIFT_MIN    = 4;
  localparam int SHIFT_MAX    = 12;
  localparam int SHIFT_RESET  = 6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the accepted item
    logic step;  // emit one sub-request into the output register
  } clas_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register is empty or being taken
    logic size_nz;    // incoming item has a nonzero size
    logic step_last;  // the sub-request being formed is the final one
  } clas_stat_t;

endpackage

// File: src/clas_stream_if.sv
// Handshake interfaces for the access channel and the sub-request channel.
`timescale 1ns / 1ps
interface clas_in_if
  import clas_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              action;
  logic              path;
  logic [ADDR_W-1:0] address;
  logic [SIZE_W-1:0] size;

  modport source (output valid, action, path, address, size, input ready);
  modport sink   (input valid, action, path, address, size, output ready);
endinterface

interface clas_out_if
  import clas_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] sub_address;
  logic [SIZE_W-1:0] chunk_bytes;
  logic [OFF_W-1:0]  src_offset;
  logic [SIZE_W-1:0] copy_bytes;
  logic              is_write;
  logic              is_mmio;
  logic              truncated;
  logic              last;

  modport source (output valid, sub_address, chunk_bytes, src_offset, copy_bytes,
                  is_write, is_mmio, truncated, last, input ready);
  modport sink   (input valid, sub_address, chunk_bytes, src_offset, copy_bytes,
                  is_write, is_mmio, truncated, last, output ready);
endinterface

// File: src/clas_ctrl.sv
// Controller state machine of the cache line access splitter.
`timescale 1ns / 1ps
module clas_ctrl
  import clas_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  clas_stat_t stat,
  output clas_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == ST_IDLE);
  assign cmd.load = in_valid && (state == ST_IDLE);
  assign cmd.step = (state == ST_RUN) && stat.out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load && stat.size_nz) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd.step && stat.step_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/clas_dp.sv
// Datapath of the cache line access splitter: access registers, chunk math, output register.
`timescale 1ns / 1ps
module clas_dp
  import clas_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  clas_cmd_t          cmd,
  output clas_stat_t         stat,
  input  logic               cfg_valid,
  input  logic [SHIFT_W-1:0] cfg_data,
  input  logic               in_action,
  input  logic               in_path,
  input  logic [ADDR_W-1:0]  in_address,
  input  logic [SIZE_W-1:0]  in_size,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [ADDR_W-1:0]  out_sub_address,
  output logic [SIZE_W-1:0]  out_chunk_bytes,
  output logic [OFF_W-1:0]   out_src_offset,
  output logic [SIZE_W-1:0]  out_copy_bytes,
  output logic               out_is_write,
  output logic               out_is_mmio,
  output logic               out_truncated,
  output logic               out_last
);

  logic [SHIFT_W-1:0] line_shift;
  logic [ADDR_W-1:0]  addr;
  logic [SIZE_W-1:0]  rem;
  logic [SIZE_W-1:0]  off;
  logic [CNT_W-1:0]   cnt;
  logic               wr;
  logic               mmio;

  logic [SHIFT_W-1:0] sh_c;
  logic [LINE_W-1:0]  line_sz;
  logic [LINE_W-1:0]  room;
  logic [SIZE_W-1:0]  c_chunk;
  logic [SIZE_W-1:0]  avail;
  logic [SIZE_W-1:0]  c_copy;
  logic [SIZE_W-1:0]  rem_after;
  logic               c_last;
  logic               m_trunc;
  logic [SIZE_W-1:0]  m_len;
  logic [SIZE_W-1:0]  size_sat;

  // Sizes above the largest access saturate.
  assign size_sat = (in_size > SIZE_W'(MAX_ACCESS)) ? SIZE_W'(MAX_ACCESS) : in_size;

  // Clamp the line shift into its legal range.
  always_comb begin
    if (line_shift < SHIFT_W'(SHIFT_MIN)) begin
      sh_c = SHIFT_W'(SHIFT_MIN);
    end else if (line_shift > SHIFT_W'(SHIFT_MAX)) begin
      sh_c = SHIFT_W'(SHIFT_MAX);
    end else begin
      sh_c = line_shift;
    end
  end

  assign line_sz = LINE_W'(1) << sh_c;
  assign room    = line_sz - (addr[LINE_W-1:0] & (line_sz - LINE_W'(1)));
  assign c_chunk = (room < LINE_W'(rem)) ? room[SIZE_W-1:0] : rem;
  assign avail   = SIZE_W'(DATA_CAP) - off;

  always_comb begin
    c_copy = '0;
    if (wr && (off < SIZE_W'(DATA_CAP))) begin
      c_copy = (c_chunk < avail) ? c_chunk : avail;
    end
  end

  assign rem_after = rem - c_chunk;
  assign c_last    = (rem_after == '0) || (cnt == CNT_W'(RESULT_LIMIT - 1));

  // An MMIO write beyond the data capacity is cut down and flagged.
  assign m_trunc = wr && (rem > SIZE_W'(DATA_CAP));
  assign m_len   = m_trunc ? SIZE_W'(DATA_CAP) : rem;

  assign stat.out_free  = !out_valid || out_ready;
  assign stat.size_nz   = (in_size != '0);
  assign stat.step_last = mmio || c_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_shift <= SHIFT_W'(SHIFT_RESET);
    end else if (cfg_valid) begin
      line_shift <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr <= in_address;
      rem  <= size_sat;
      off  <= '0;
      cnt  <= '0;
      wr   <= in_action;
      mmio <= in_path;
    end else if (cmd.step) begin
      addr <= addr + ADDR_W'(c_chunk);
      rem  <= rem_after;
      off  <= off + c_chunk;
      cnt  <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_sub_address <= addr;
      out_is_write    <= wr;
      out_is_mmio     <= mmio;
      if (mmio) begin
        out_chunk_bytes <= m_len;
        out_src_offset  <= '0;
        out_copy_bytes  <= wr ? m_len : '0;
        out_truncated   <= m_trunc;
        out_last        <= 1'b1;
      end else begin
        out_chunk_bytes <= c_chunk;
        out_src_offset  <= off[OFF_W-1:0];
        out_copy_bytes  <= c_copy;
        out_truncated   <= 1'b0;
        out_last        <= c_last;
      end
    end
  end

endmodule

// File: src/cache_line_access_splitter_top.sv
// Top level of the cache line access splitter.
`timescale 1ns / 1ps
// The splitter takes one memory access item on req and issues its sub-requests on
// sub. A cached access is cut at every cache line boundary, the line size being
// 2**line_shift bytes (clamped to 16..4096, reset 64); an MMIO access gives one
// sub-request, and an MMIO write longer than 64 bytes is cut to 64 and flagged as
// truncated. Sizes above 512 act as 512, a zero size gives no sub-request, and the
// final sub-request of an access carries last. An access is accepted in the idle
// state and its sub-requests are then formed in the run state; the chunk loop in
// the datapath forms one sub-request per cycle while the output register is free,
// and no new access is accepted until the last sub-request is formed. A sub-request
// waiting on a stalled sub channel holds in the output register while the next
// access can already be accepted. line_shift is written on the cfg port, which is
// always ready, and should only be written while no access is in flight.
module cache_line_access_splitter_top
  import clas_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  clas_in_if.sink            req,
  clas_out_if.source         sub,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SHIFT_W-1:0] cfg_data
);

  clas_cmd_t  cmd;
  clas_stat_t stat;

  // The line size register can always take a write.
  assign cfg_ready = 1'b1;

  // The controller owns the accept and sequencing decisions.
  clas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the access being split and the output register.
  clas_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .in_action       (req.action),
    .in_path         (req.path),
    .in_address      (req.address),
    .in_size         (req.size),
    .out_ready       (sub.ready),
    .out_valid       (sub.valid),
    .out_sub_address (sub.sub_address),
    .out_chunk_bytes (sub.chunk_bytes),
    .out_src_offset  (sub.src_offset),
    .out_copy_bytes  (sub.copy_bytes),
    .out_is_write    (sub.is_write),
    .out_is_mmio     (sub.is_mmio),
    .out_truncated   (sub.truncated),
    .out_last        (sub.last)
  );

endmodule

// File: src/clas_checker.sv
// Port-level checker for the cache line access splitter, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module clas_checker
  import clas_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [SIZE_W-1:0] in_size,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ADDR_W-1:0] sub_address,
  input logic [SIZE_W-1:0] chunk_bytes,
  input logic [SIZE_W-1:0] copy_bytes,
  input logic              is_write,
  input logic              is_mmio,
  input logic              truncated,
  input logic              last
);

  // An accepted access with work to do blocks the next one; ready is low in the following cycle.
  `CLAS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready && (in_size != '0), !in_ready, "access accepted while busy")

  // A stalled sub-request holds.
  `CLAS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(sub_address) && $stable(chunk_bytes), "stalled sub-request changed")

  // Lengths are never zero and copies never exceed the chunk; reads copy nothing.
  `CLAS_ASSERT_IMPL(a_len_ok, clk, rst, out_valid, (chunk_bytes != '0) && (copy_bytes <= chunk_bytes) && (is_write || (copy_bytes == '0)), "bad chunk or copy length")

  // MMIO gives one final sub-request; truncation only on full-capacity MMIO writes.
  `CLAS_ASSERT_IMPL(a_mmio_ok, clk, rst, out_valid && (is_mmio || truncated), last && is_mmio && (!truncated || (is_write && (chunk_bytes == SIZE_W'(DATA_CAP)))), "bad MMIO sub-request")

endmodule

bind cache_line_access_splitter_top clas_checker u_clas_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .in_size     (req.size),
  .out_valid   (sub.valid),
  .out_ready   (sub.ready),
  .sub_address (sub.sub_address),
  .chunk_bytes (sub.chunk_bytes),
  .copy_bytes  (sub.copy_bytes),
  .is_write    (sub.is_write),
  .is_mmio     (sub.is_mmio),
  .truncated   (sub.truncated),
  .last        (sub.last)
);

// File: test/testbench.sv
// Self-checking testbench for the cache line access splitter with an inline predictor.
`timescale 1ns / 1ps
module testbench;
  import clas_pkg::*;

  // Codes of the access item fields.
  localparam logic ACT_READ    = 1'b0;
  localparam logic ACT_WRITE   = 1'b1;
  localparam logic PATH_CACHED = 1'b0;
  localparam logic PATH_MMIO   = 1'b1;

  localparam logic [ADDR_W-1:0] ADDR_TOP = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int N_DIRECTED = 23;
  localparam int N_PHASES = 16;
  localparam int ITEMS_PER_PHASE = 23;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic              action;
    logic              path;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size;
  } access_t;

  typedef struct packed {
    logic [ADDR_W-1:0] sub_address;
    logic [SIZE_W-1:0] chunk_bytes;
    logic [OFF_W-1:0]  src_offset;
    logic [SIZE_W-1:0] copy_bytes;
    logic              is_write;
    logic              is_mmio;
    logic              truncated;
    logic              last;
  } subreq_t;

  // How the expectation of a directed row is formed.
  typedef enum logic [1:0] {
    ROW_PREDICT,  // worked out by the predictor
    ROW_NONE,     // the access gives no sub-request
    ROW_ONE       // exactly the one sub-request typed into the row
  } row_kind_t;

  typedef struct {
    logic [SHIFT_W-1:0] shift;
    access_t            acc;
    row_kind_t          kind;
    subreq_t            exp;
  } dir_row_t;

  localparam subreq_t NO_SUBREQ = '0;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [SHIFT_W-1:0] cfg_data;

  clas_in_if  req();
  clas_out_if sub();

  cache_line_access_splitter_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .sub       (sub),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Predictor state: our own copy of the line shift register.
  logic [SHIFT_W-1:0] cur_line_shift;
  subreq_t pending_subreqs [$];
  int mismatch_count;
  bit no_idle;
  int rx_stall_left;
  dir_row_t directed_rows [N_DIRECTED];
  logic [SHIFT_W-1:0] phase_shifts [N_PHASES];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run, well above the slowest legal run.
  initial begin
    #25ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic string fmt_subreq(input subreq_t s);
    return $sformatf("addr=%h len=%0d off=%0d copy=%0d wr=%b mmio=%b trunc=%b last=%b",
                     s.sub_address, s.chunk_bytes, s.src_offset, s.copy_bytes,
                     s.is_write, s.is_mmio, s.truncated, s.last);
  endfunction

  // Work out the sub-requests of one access under the current line shift and
  // queue them in order.
  function automatic void predict_subreqs(input access_t a);
    logic [63:0] sz, len, sh, line, mask, addr, off, remaining, room, chunk, copy, avail;
    int n;
    subreq_t s;
    sz = 64'(a.size);
    if (sz > MAX_ACCESS) sz = 64'(MAX_ACCESS);
    if (sz == 0) return;
    if (a.path == PATH_MMIO) begin
      // One request; an MMIO write is cut to the data capacity.
      len = sz;
      s.truncated = 1'b0;
      if (a.action == ACT_WRITE && sz > DATA_CAP) begin
        len = 64'(DATA_CAP);
        s.truncated = 1'b1;
      end
      s.sub_address = a.address;
      s.chunk_bytes = len[SIZE_W-1:0];
      s.src_offset  = '0;
      s.copy_bytes  = (a.action == ACT_WRITE) ? len[SIZE_W-1:0] : '0;
      s.is_write    = a.action;
      s.is_mmio     = 1'b1;
      s.last        = 1'b1;
      pending_subreqs.push_back(s);
      return;
    end
    sh = 64'(cur_line_shift);
    if (sh < SHIFT_MIN) sh = 64'(SHIFT_MIN);
    if (sh > SHIFT_MAX) sh = 64'(SHIFT_MAX);
    line = 64'd1 << sh;
    mask = line - 64'd1;
    addr = a.address;
    off = '0;
    remaining = sz;
    n = 0;
    while (remaining > 0 && n < RESULT_LIMIT) begin
      room = line - (addr & mask);
      chunk = (room < remaining) ? room : remaining;
      copy = '0;
      // Only the first DATA_CAP bytes of the write data exist.
      if (a.action == ACT_WRITE && off < DATA_CAP) begin
        avail = 64'(DATA_CAP) - off;
        copy = (chunk < avail) ? chunk : avail;
      end
      remaining = remaining - chunk;
      s.sub_address = addr;
      s.chunk_bytes = chunk[SIZE_W-1:0];
      s.src_offset  = off[OFF_W-1:0];
      s.copy_bytes  = copy[SIZE_W-1:0];
      s.is_write    = a.action;
      s.is_mmio     = 1'b0;
      s.truncated   = 1'b0;
      s.last        = (remaining == 0 || n == RESULT_LIMIT - 1);
      pending_subreqs.push_back(s);
      n++;
      addr = addr + chunk;  // wraps past the top of the address space
      off = off + chunk;
    end
  endfunction

  function automatic void log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic access_t random_access();
    access_t a;
    logic [ADDR_W-1:0] base;
    a.action = ($urandom_range(0, 1) == 0) ? ACT_READ : ACT_WRITE;
    a.path = ($urandom_range(0, 9) < 3) ? PATH_MMIO : PATH_CACHED;
    base = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: a.address = base;
      1: begin
        // Just below a 4 KiB boundary, which is a line boundary for every line size.
        base[11:0] = 12'hFFF - 12'($urandom_range(0, 31));
        a.address = base;
      end
      2: a.address = ADDR_TOP - 64'($urandom_range(0, 600));
      default: a.address = 64'($urandom_range(0, 8191));
    endcase
    case ($urandom_range(0, 15))
      0: a.size = '0;
      1: a.size = SIZE_W'($urandom_range(MAX_ACCESS + 1, 1023));
      2, 3: a.size = SIZE_W'($urandom_range(DATA_CAP + 1, MAX_ACCESS));
      default: a.size = SIZE_W'($urandom_range(1, DATA_CAP));
    endcase
    return a;
  endfunction

  // Offer one access and queue its expectation at the edge that accepts it.
  // valid stays high across back-to-back items.
  task automatic send_access(input access_t a, input row_kind_t kind, input subreq_t typed);
    int g;
    g = pick_gap();
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.action  <= a.action;
    req.path    <= a.path;
    req.address <= a.address;
    req.size    <= a.size;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    case (kind)
      ROW_ONE:     pending_subreqs.push_back(typed);
      ROW_PREDICT: predict_subreqs(a);
      default: ;
    endcase
  endtask

  // Stop offering items and wait until every expected sub-request has come,
  // then wait out a settle time in case a zero-size access is still in flight.
  task automatic drain();
    req.valid <= 1'b0;
    while (pending_subreqs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_line_shift(input logic [SHIFT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_line_shift = v;
  endtask

  // Receiver with random back-pressure.
  initial begin
    rx_stall_left = 0;
    sub.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_stall_left != 0) begin
        rx_stall_left--;
        sub.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        rx_stall_left = pick_gap();
        sub.ready <= 1'b0;
      end else begin
        sub.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted sub-request with the oldest expectation.
  always @(posedge clk) begin
    subreq_t got, want;
    if (!rst && sub.valid && sub.ready) begin
      got = '{sub.sub_address, sub.chunk_bytes, sub.src_offset, sub.copy_bytes,
              sub.is_write, sub.is_mmio, sub.truncated, sub.last};
      if (pending_subreqs.size() == 0) begin
        log_mismatch({"unexpected sub-request ", fmt_subreq(got)});
      end else begin
        want = pending_subreqs.pop_front();
        if (got !== want)
          log_mismatch({"expected ", fmt_subreq(want), " got ", fmt_subreq(got)});
      end
    end
  end

  initial begin
    mismatch_count = 0;
    no_idle = 1'b0;
    cur_line_shift = SHIFT_W'(SHIFT_RESET);
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.action <= ACT_READ;
    req.path <= PATH_CACHED;
    req.address <= '0;
    req.size <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;

    // Directed rows: field extremes, both paths and actions, zero size,
    // truncation, saturation, address wrap, the 33-result access and the
    // clamped line shifts.
    directed_rows = '{
      '{4'd6, '{ACT_READ, PATH_CACHED, 64'h0, 10'd1}, ROW_ONE,
        '{64'h0, 10'd1, 9'd0, 10'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{4'd6, '{ACT_WRITE, PATH_CACHED, 64'h0, 10'd64}, ROW_ONE,
        '{64'h0, 10'd64, 9'd0, 10'd64, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{4'd6, '{ACT_READ, PATH_CACHED, 64'h40, 10'd0}, ROW_NONE, NO_SUBREQ},
      '{4'd6, '{ACT_WRITE, PATH_MMIO, 64'h80, 10'd0}, ROW_NONE, NO_SUBREQ},
      '{4'd6, '{ACT_READ, PATH_MMIO, ADDR_TOP, 10'd512}, ROW_ONE,
        '{ADDR_TOP, 10'd512, 9'd0, 10'd0, 1'b0, 1'b1, 1'b0, 1'b1}},
      '{4'd6, '{ACT_WRITE, PATH_MMIO, 64'h1234, 10'd100}, ROW_ONE,
        '{64'h1234, 10'd64, 9'd0, 10'd64, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{4'd6, '{ACT_WRITE, PATH_MMIO, 64'h1000, 10'd64}, ROW_ONE,
        '{64'h1000, 10'd64, 9'd0, 10'd64, 1'b1, 1'b1, 1'b0, 1'b1}},
      '{4'd6, '{ACT_WRITE, PATH_MMIO, ADDR_TOP, 10'd1023}, ROW_ONE,
        '{ADDR_TOP, 10'd64, 9'd0, 10'd64, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{4'd6, '{ACT_READ, PATH_MMIO, 64'h0, 10'd1023}, ROW_ONE,
        '{64'h0, 10'd512, 9'd0, 10'd0, 1'b0, 1'b1, 1'b0, 1'b1}},
      '{4'd6, '{ACT_WRITE, PATH_CACHED, 64'h3F, 10'd2}, ROW_PREDICT, NO_SUBREQ},
      '{4'd6, '{ACT_READ, PATH_CACHED, 64'h0, 10'd512}, ROW_PREDICT, NO_SUBREQ},
      '{4'd6, '{ACT_WRITE, PATH_CACHED, 64'h1, 10'd512}, ROW_PREDICT, NO_SUBREQ},
      '{4'd6, '{ACT_WRITE, PATH_CACHED, 64'h20, 10'd1023}, ROW_PREDICT, NO_SUBREQ},
      '{4'd6, '{ACT_READ, PATH_CACHED, 64'hFFFF_FFFF_FFFF_FFF0, 10'd64}, ROW_PREDICT,
        NO_SUBREQ},
      '{4'd6, '{ACT_WRITE, PATH_CACHED, ADDR_TOP, 10'd512}, ROW_PREDICT, NO_SUBREQ},
      '{4'd6, '{ACT_READ, PATH_CACHED, 64'hAAAA_5555_AAAA_5555, 10'h2AA}, ROW_PREDICT,
        NO_SUBREQ},
      '{4'd6, '{ACT_WRITE, PATH_CACHED, 64'h5555_AAAA_5555_AAAA, 10'h155}, ROW_PREDICT,
        NO_SUBREQ},
      '{4'd4, '{ACT_WRITE, PATH_CACHED, 64'h8, 10'd512}, ROW_PREDICT, NO_SUBREQ},
      '{4'd4, '{ACT_READ, PATH_CACHED, 64'h0, 10'd512}, ROW_PREDICT, NO_SUBREQ},
      '{4'd0, '{ACT_WRITE, PATH_CACHED, 64'hF, 10'd300}, ROW_PREDICT, NO_SUBREQ},
      '{4'd12, '{ACT_READ, PATH_CACHED, 64'hFFF, 10'd512}, ROW_PREDICT, NO_SUBREQ},
      '{4'd15, '{ACT_WRITE, PATH_CACHED, 64'hFF0, 10'd512}, ROW_PREDICT, NO_SUBREQ},
      '{4'd15, '{ACT_READ, PATH_MMIO, 64'h10, 10'd1}, ROW_ONE,
        '{64'h10, 10'd1, 9'd0, 10'd0, 1'b0, 1'b1, 1'b0, 1'b1}}
    };
    // Every line shift value, clamped ones and both extremes included.
    phase_shifts = '{4'd12, 4'd0, 4'd15, 4'd6, 4'd5, 4'd3, 4'd13, 4'd8,
                     4'd10, 4'd4, 4'd7, 4'd9, 4'd11, 4'd14, 4'd1, 4'd2};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // The first rows run with the reset line shift; the register is only
    // rewritten once the splitter has gone quiet.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].shift != cur_line_shift) begin
        drain();
        write_line_shift(directed_rows[i].shift);
      end
      send_access(directed_rows[i].acc, directed_rows[i].kind, directed_rows[i].exp);
    end

    // Random phases, one per line shift; every third one runs without idling.
    foreach (phase_shifts[p]) begin
      drain();
      write_line_shift(phase_shifts[p]);
      no_idle = (p % 3 == 2);
      repeat (ITEMS_PER_PHASE) send_access(random_access(), ROW_PREDICT, NO_SUBREQ);
    end

    drain();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
